/* sv/speck64_128_block_cipher_core_assert.svh */
// Assertion macros for the Speck64/128 cipher core
`ifndef SPECK64_128_BLOCK_CIPHER_CORE_ASSERT_SVH
`define SPECK64_128_BLOCK_CIPHER_CORE_ASSERT_SVH

// same-cycle implication
`define SP64_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SP64_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/sp64_pkg.sv */
// Shared constants, types and word functions of the Speck64/128 cipher core
package sp64_pkg;

   localparam int ROUNDS    = 27;
   localparam int ROT_A     = 8;
   localparam int ROT_B     = 3;
   localparam int WORD_W    = 32;
   localparam int BLOCK_W   = 2 * WORD_W;
   localparam int KEY_W     = 64;
   localparam int CSR_IDX_W = 1;
   localparam int RND_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_UPPER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LOWER = 1'b1;

   localparam logic REQ_ENCRYPT = 1'b0;
   localparam logic REQ_DECRYPT = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [ROUNDS-1:0] rkeys_type;

   typedef struct packed {
      logic     valid;
      logic     dec;
      word_type x;
      word_type y;
   } stage_type;

   typedef struct packed {
      logic busy;
   } ks_status_type;

   function automatic word_type rotr(input word_type v, input int r);
      return (v >> r) | (v << (WORD_W - r));
   endfunction

   function automatic word_type rotl(input word_type v, input int r);
      return (v << r) | (v >> (WORD_W - r));
   endfunction

   function automatic word_type swap32(input word_type v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

/* sv/sp64_chan_if.sv */
// Valid/ready channel interfaces of the Speck64/128 cipher core
interface sp64_req_if;
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic [sp64_pkg::BLOCK_W-1:0] block_in;

   modport source (output valid, output req_type, output block_in, input ready);
   modport sink   (input valid, input req_type, input block_in, output ready);
endinterface

interface sp64_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [sp64_pkg::BLOCK_W-1:0] block_out;

   modport source (output valid, output block_out, input ready);
   modport sink   (input valid, input block_out, output ready);
endinterface

interface sp64_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sp64_pkg::CSR_IDX_W-1:0] index;
   logic [sp64_pkg::KEY_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/sp64_key_sched.sv */
// Key registers and sequential round key expansion
module sp64_key_sched (
   input  logic                    clock,
   input  logic                    reset,
   sp64_csr_if.sink                csr,
   output sp64_pkg::rkeys_type     rkeys,
   output sp64_pkg::ks_status_type status
);

   logic [sp64_pkg::KEY_W-1:0] key_upper_ff;
   logic [sp64_pkg::KEY_W-1:0] key_lower_ff;
   logic                       load_ff;
   logic                       run_ff;
   logic                       run_in;
   logic [sp64_pkg::RND_W-1:0] cnt_ff;
   logic [sp64_pkg::RND_W-1:0] cnt_in;
   sp64_pkg::word_type         k_ff;
   sp64_pkg::word_type         k_in;
   sp64_pkg::word_type         q_ff [3];
   sp64_pkg::word_type         nl;
   sp64_pkg::rkeys_type        rk_ff;
   logic                       last_step;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            sp64_pkg::REG_KEY_UPPER: key_upper_ff <= csr.data;
            sp64_pkg::REG_KEY_LOWER: key_lower_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign nl        = (k_ff + sp64_pkg::rotr(q_ff[0], sp64_pkg::ROT_A))
                      ^ sp64_pkg::word_type'(cnt_ff);
   assign k_in      = sp64_pkg::rotl(k_ff, sp64_pkg::ROT_B) ^ nl;
   assign last_step = (32'(cnt_ff) == 32'(sp64_pkg::ROUNDS - 2));
   assign cnt_in    = cnt_ff + 1'b1;

   always_comb begin
      run_in = run_ff;
      if (load_ff) begin
         run_in = (sp64_pkg::ROUNDS > 1);
      end else if (run_ff && last_step) begin
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b1;
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         load_ff <= csr.valid;
         run_ff  <= run_in;
         if (load_ff) begin
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ff) begin
         k_ff     <= sp64_pkg::swap32(key_upper_ff[63:32]);
         q_ff[0]  <= sp64_pkg::swap32(key_upper_ff[31:0]);
         q_ff[1]  <= sp64_pkg::swap32(key_lower_ff[63:32]);
         q_ff[2]  <= sp64_pkg::swap32(key_lower_ff[31:0]);
         rk_ff[0] <= sp64_pkg::swap32(key_upper_ff[63:32]);
      end else if (run_ff) begin
         k_ff           <= k_in;
         q_ff[0]        <= q_ff[1];
         q_ff[1]        <= q_ff[2];
         q_ff[2]        <= nl;
         rk_ff[cnt_in]  <= k_in;
      end
   end

   assign rkeys       = rk_ff;
   assign status.busy = load_ff || run_ff;

endmodule

/* sv/sp64_round_cell.sv */
// One round cell: forward or inverse Speck round with its stage register
module sp64_round_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  sp64_pkg::stage_type stage_in,
   input  sp64_pkg::word_type  rk_enc,
   input  sp64_pkg::word_type  rk_dec,
   output sp64_pkg::stage_type stage_out
);

   sp64_pkg::stage_type out_ff;
   sp64_pkg::stage_type out_in;
   sp64_pkg::word_type  ex;
   sp64_pkg::word_type  ey;
   sp64_pkg::word_type  dx;
   sp64_pkg::word_type  dy;

   assign ex = (sp64_pkg::rotr(stage_in.x, sp64_pkg::ROT_A) + stage_in.y) ^ rk_enc;
   assign ey = sp64_pkg::rotl(stage_in.y, sp64_pkg::ROT_B) ^ ex;
   assign dy = sp64_pkg::rotr(stage_in.y ^ stage_in.x, sp64_pkg::ROT_B);
   assign dx = sp64_pkg::rotl((stage_in.x ^ rk_dec) - dy, sp64_pkg::ROT_A);

   always_comb begin
      out_in.valid = stage_in.valid;
      out_in.dec   = stage_in.dec;
      out_in.x     = (stage_in.dec == sp64_pkg::REQ_DECRYPT) ? dx : ex;
      out_in.y     = (stage_in.dec == sp64_pkg::REQ_DECRYPT) ? dy : ey;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         out_ff <= out_in;
      end
   end

   assign stage_out = out_ff;

endmodule

/* sv/speck64_128_block_cipher_core.sv */
// Speck64/128 encrypt/decrypt core: round key sequencer and chain of round cells
//
// One block is accepted per clock cycle while req_chan.ready is high; its result
// passes the registers of the 27 round cells; encrypt and decrypt transactions mix
// freely in the chain. The whole chain holds while a finished result waits on
// rsp_chan. Round keys are expanded one per cycle by a sequencer after reset and
// every key write; in its one load plus 26 steps req_chan.ready stays low.
// Key registers take writes on csr_chan (ready is always high); write them only
// while no transaction is in flight, since the round cells read the keys live.
`include "speck64_128_block_cipher_core_assert.svh"

module speck64_128_block_cipher_core (
   input  logic     clock,
   input  logic     reset,
   sp64_req_if.sink   req_chan,
   sp64_rsp_if.source rsp_chan,
   sp64_csr_if.sink   csr_chan
);

   sp64_pkg::rkeys_type     rkeys;
   sp64_pkg::ks_status_type ks_status;
   sp64_pkg::stage_type     chain [sp64_pkg::ROUNDS+1];
   sp64_pkg::stage_type     head;
   sp64_pkg::stage_type     last;
   logic                    enable;
   logic                    accept;
   logic                    is_dec;

   sp64_key_sched u_key_sched (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr_chan),
      .rkeys  (rkeys),
      .status (ks_status)
   );

   assign last   = chain[sp64_pkg::ROUNDS];
   assign enable = !last.valid || rsp_chan.ready;
   assign req_chan.ready = enable && !ks_status.busy && !csr_chan.valid;
   assign accept = req_chan.valid && req_chan.ready;
   assign is_dec = (req_chan.req_type == sp64_pkg::REQ_DECRYPT);

   always_comb begin
      head.valid = accept;
      head.dec   = req_chan.req_type;
      head.x     = is_dec ? req_chan.block_in[63:32]
                          : sp64_pkg::swap32(req_chan.block_in[31:0]);
      head.y     = is_dec ? req_chan.block_in[31:0]
                          : sp64_pkg::swap32(req_chan.block_in[63:32]);
   end

   assign chain[0] = head;

   for (genvar i = 0; i < sp64_pkg::ROUNDS; i++) begin : g_cell
      sp64_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_in  (chain[i]),
         .rk_enc    (rkeys[i]),
         .rk_dec    (rkeys[sp64_pkg::ROUNDS-1-i]),
         .stage_out (chain[i+1])
      );
   end

   assign rsp_chan.valid     = last.valid;
   assign rsp_chan.block_out = (last.dec == sp64_pkg::REQ_DECRYPT)
                               ? {sp64_pkg::swap32(last.y), sp64_pkg::swap32(last.x)}
                               : {last.x, last.y};

   `SP64_ASSERT_NOW(a_no_accept_busy, ks_status.busy, !req_chan.ready,
      "transaction accepted during round key expansion")
   `SP64_ASSERT_NEXT(a_write_starts_sched, csr_chan.valid && csr_chan.ready, ks_status.busy,
      "key write did not restart round key expansion")
   `SP64_ASSERT_NEXT(a_accept_enters_chain, accept, chain[1].valid,
      "accepted transaction did not enter the first round cell")
   `SP64_ASSERT_NEXT(a_stall_holds_last, !enable, $stable(last),
      "last round cell changed while the chain was held")

endmodule
